// ===== sv/oriented_box_corner_generator_defines.svh =====
// Assertion macros shared by the box corner generator modules.
`ifndef ORIENTED_BOX_CORNER_GENERATOR_DEFINES_SVH
`define ORIENTED_BOX_CORNER_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define OBCG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Checked on every clock edge, reset included.
`define OBCG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define OBCG_ASSERT(label, prop)
`define OBCG_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== sv/obcg_pkg.sv =====
// Types, constants and helpers for the oriented box corner generator.
package obcg_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int EXT_W        = 24;

  localparam int PHASE_W   = 32;
  localparam int PHASE_PAD = PHASE_W - ANGLE_W;
  localparam int ATAN_N    = 24;
  localparam int NSTEP     = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

  // CORDIC datapath: Q30 trig values, phase residual with one guard bit
  localparam int TRIG_W = 32;
  localparam int ANG_W  = PHASE_W + 1;

  // products of trig values and extents, and their signed sums
  localparam int PROD_W = TRIG_W + EXT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC   = 31;
  localparam int RX_W   = SUM_W - FRAC;
  localparam int WIDE_W = COORD_W + EXT_W + 2;

  localparam logic [2:0] LAST_CORNER = 3'd7;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [RX_W-1:0]   rx_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EXT_W:0]    ext_s_t;

  localparam trig_t INV_GAIN = trig_t'(652032874);
  localparam sum_t  ROUND    = sum_t'(1) <<< (FRAC - 1);

  localparam ang_t ATAN_TAB [ATAN_N] = '{
    ang_t'(536870912), ang_t'(316933406), ang_t'(167458907), ang_t'(85004756),
    ang_t'(42667331),  ang_t'(21354465),  ang_t'(10679838),  ang_t'(5340245),
    ang_t'(2670163),   ang_t'(1335087),   ang_t'(667544),    ang_t'(333772),
    ang_t'(166886),    ang_t'(83443),     ang_t'(41722),     ang_t'(20861),
    ang_t'(10430),     ang_t'(5215),      ang_t'(2608),      ang_t'(1304),
    ang_t'(652),       ang_t'(326),       ang_t'(163),       ang_t'(81)
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [EXT_W-1:0]          len;
    logic [EXT_W-1:0]          wid;
    logic [EXT_W-1:0]          hgt;
    logic signed [ANGLE_W-1:0] yaw;
  } box_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'({1'b0, {(COORD_W - 1){1'b1}}});
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      sat_coord = coord_t'(hi);
    end else if (v < lo) begin
      sat_coord = coord_t'(lo);
    end else begin
      sat_coord = coord_t'(v);
    end
  endfunction

endpackage

// ===== sv/obcg_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cos and sin of the box heading.
`include "oriented_box_corner_generator_defines.svh"
module obcg_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  obcg_pkg::box_t  in_box,
  output logic            out_valid,
  output obcg_pkg::box_t  out_box,
  output obcg_pkg::trig_t out_cos,
  output obcg_pkg::trig_t out_sin
);
  import obcg_pkg::*;

  logic  v    [0:NSTEP];
  box_t  bx   [0:NSTEP];
  trig_t x    [0:NSTEP];
  trig_t y    [0:NSTEP];
  ang_t  z    [0:NSTEP];
  logic  flip [0:NSTEP];

  logic [PHASE_W-1:0] phase;
  logic               flip_in;
  logic [PHASE_W-1:0] phase_fold;

  // fold the second and third quadrants by half a turn
  assign phase      = {in_box.yaw, PHASE_PAD'(0)};
  assign flip_in    = phase[PHASE_W-1] ^ phase[PHASE_W-2];
  assign phase_fold = {phase[PHASE_W-1] ^ flip_in, phase[PHASE_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bx[0]   <= in_box;
      x[0]    <= INV_GAIN;
      y[0]    <= '0;
      z[0]    <= ang_t'($signed(phase_fold));
      flip[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    trig_t xs;
    trig_t ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        bx[i+1]   <= bx[i];
        flip[i+1] <= flip[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = v[NSTEP];
  assign out_box   = bx[NSTEP];
  assign out_cos   = flip[NSTEP] ? -x[NSTEP] : x[NSTEP];
  assign out_sin   = flip[NSTEP] ? -y[NSTEP] : y[NSTEP];

  `OBCG_ASSERT(a_enter, adv && in_valid |=> v[0])
  `OBCG_ASSERT(a_freeze, !adv |=> out_valid == $past(out_valid))
  `OBCG_ASSERT(a_shift, adv |=> out_valid == $past(v[NSTEP-1]))

endmodule

// ===== sv/oriented_box_corner_generator.sv =====
// Top level: heading CORDIC, per-box products and the eight-corner emitter.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_ready  | center_x_in/y/z, box_length/width/height, yaw
//   output  | out_valid / out_ready| corner_x/y/z, corner_index, last_corner
//
// Sustained, the single result channel carries eight corners per box, one per cycle
// while the output is not stalled; a new box enters the product stage as the last
// corner of the previous one moves on. The first corner of a box passes the CORDIC
// stages, product stage, sum stage and saturating output stage after acceptance.
// Reset clears the valid bits and the corner counter; payload registers are not reset.
// A stall on the output freezes the corner stages and, once they are full, the CORDIC.
`include "oriented_box_corner_generator_defines.svh"
module oriented_box_corner_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [obcg_pkg::COORD_W-1:0] center_x_in,
  input  logic signed [obcg_pkg::COORD_W-1:0] center_y_in,
  input  logic signed [obcg_pkg::COORD_W-1:0] center_z_in,
  input  logic [obcg_pkg::EXT_W-1:0]          box_length,
  input  logic [obcg_pkg::EXT_W-1:0]          box_width,
  input  logic [obcg_pkg::EXT_W-1:0]          box_height,
  input  logic signed [obcg_pkg::ANGLE_W-1:0] yaw_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [obcg_pkg::COORD_W-1:0] corner_x,
  output logic signed [obcg_pkg::COORD_W-1:0] corner_y,
  output logic signed [obcg_pkg::COORD_W-1:0] corner_z,
  output logic [2:0]                         corner_index,
  output logic                               last_corner
);
  import obcg_pkg::*;

  box_t  in_box;
  logic  c_v;
  box_t  c_box;
  trig_t c_cos;
  trig_t c_sin;
  logic  c_adv;

  // product stage: one box, walked through its eight corners
  logic       p_v;
  logic [2:0] p_k;
  prod_t      p_cl, p_cw, p_sl, p_sw;
  coord_t     p_cx, p_cy, p_cz;
  ext_s_t     p_hgt;

  // sum stage
  logic       b_v;
  logic [2:0] b_k;
  rx_t        b_rx, b_ry;
  logic signed [WIDE_W-2:0] b_z;
  coord_t     b_cx, b_cy;

  // output register
  logic       o_v;

  logic   adv;
  logic   p_done;
  logic   take;
  ext_s_t len_s, wid_s;
  prod_t  cl_mul, cw_mul, sl_mul, sw_mul;
  sum_t   tx, ty, dcl, dcw, dsl, dsw;
  wide_t  tz, hz;

  assign in_box = '{cx: center_x_in, cy: center_y_in, cz: center_z_in,
                    len: box_length, wid: box_width, hgt: box_height,
                    yaw: yaw_angle};

  assign adv    = !o_v || out_ready;
  assign p_done = adv && p_v && (p_k == LAST_CORNER);
  assign take   = c_v && (!p_v || p_done);
  assign c_adv  = !c_v || take;
  assign in_ready = c_adv;

  obcg_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (c_adv),
    .in_valid (in_valid),
    .in_box   (in_box),
    .out_valid(c_v),
    .out_box  (c_box),
    .out_cos  (c_cos),
    .out_sin  (c_sin)
  );

  assign len_s  = $signed({1'b0, c_box.len});
  assign wid_s  = $signed({1'b0, c_box.wid});
  assign cl_mul = c_cos * len_s;
  assign cw_mul = c_cos * wid_s;
  assign sl_mul = c_sin * len_s;
  assign sw_mul = c_sin * wid_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      p_k <= '0;
    end else if (take) begin
      p_v <= 1'b1;
      p_k <= '0;
    end else if (p_done) begin
      p_v <= 1'b0;
    end else if (adv && p_v) begin
      p_k <= p_k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_cl  <= cl_mul;
      p_cw  <= cw_mul;
      p_sl  <= sl_mul;
      p_sw  <= sw_mul;
      p_cx  <= c_box.cx;
      p_cy  <= c_box.cy;
      p_cz  <= c_box.cz;
      p_hgt <= $signed({1'b0, c_box.hgt});
    end
  end

  // offsets are doubled half-sizes: dx = +-length, dy = +-width, dz = +-height
  always_comb begin
    dcl = sum_t'(p_cl);
    dcw = sum_t'(p_cw);
    dsl = sum_t'(p_sl);
    dsw = sum_t'(p_sw);
    tx  = (p_k[2] ? -dcl : dcl) - (p_k[1] ? dsw : -dsw) + ROUND;
    ty  = (p_k[2] ? -dsl : dsl) + (p_k[1] ? dcw : -dcw) + ROUND;
    hz  = wide_t'(p_hgt);
    tz  = (wide_t'(p_cz) <<< 1) + (p_k[0] ? hz : -hz) + wide_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_v) begin
      b_k  <= p_k;
      b_rx <= tx[SUM_W-1:FRAC];
      b_ry <= ty[SUM_W-1:FRAC];
      b_z  <= tz[WIDE_W-1:1];
      b_cx <= p_cx;
      b_cy <= p_cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (adv) begin
      o_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_v) begin
      corner_x     <= sat_coord(wide_t'(b_cx) + wide_t'(b_rx));
      corner_y     <= sat_coord(wide_t'(b_cy) + wide_t'(b_ry));
      corner_z     <= sat_coord(wide_t'(b_z));
      corner_index <= b_k;
      last_corner  <= (b_k == LAST_CORNER);
    end
  end

  assign out_valid = o_v;

  `OBCG_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid)
  `OBCG_ASSERT(a_hold_box, p_v && !p_done |=> p_v)
  `OBCG_ASSERT(a_release, p_done && !take |=> !p_v)
  `OBCG_ASSERT(a_order, adv && b_v |=> o_v && corner_index == $past(b_k))

endmodule
